FILE: rtl/ufcf_pkg.sv
`default_nettype none

package ufcf_pkg;

  // Width of a vertex index as it arrives on the edge channel.
  localparam int unsigned VTX_W = 12;

  // Default number of vertices held in the parent table.
  localparam int unsigned VERTEX_COUNT_DEF = 4096;

  // Width of the set-generation tag stored with each parent entry.
  localparam int unsigned TAG_W = 8;

  // Tag zero marks an entry that no vertex of the live generation owns.
  localparam logic [TAG_W-1:0] TAG_NONE  = '0;
  localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] TAG_LAST  = '1;

endpackage

`default_nettype wire

FILE: rtl/ufcf_if.sv
`default_nettype none

interface ufcf_edge_if;
  logic                      valid;
  logic                      ready;
  logic [ufcf_pkg::VTX_W-1:0] tail_vertex;
  logic [ufcf_pkg::VTX_W-1:0] tip_vertex;
  logic                      new_set;

  modport source (output valid, output tail_vertex, output tip_vertex, output new_set,
                  input ready);
  modport sink   (input valid, input tail_vertex, input tip_vertex, input new_set,
                  output ready);
endinterface

interface ufcf_result_if;
  logic valid;
  logic ready;
  logic added;

  modport source (output valid, output added, input ready);
  modport sink   (input valid, input added, output ready);
endinterface

`default_nettype wire

FILE: rtl/ufcf_wrap.sv
`default_nettype none

// Reduce a raw vertex index modulo the table depth by reciprocal
// multiplication: register the quotient, then multiply back and subtract.
// Power-of-two depths reduce by truncation.
module ufcf_wrap #(
  parameter int unsigned VERTEX_COUNT = ufcf_pkg::VERTEX_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [ufcf_pkg::VTX_W-1:0]       raw,
  output logic                                  done,
  output logic [$clog2(VERTEX_COUNT)-1:0]       idx
);

  localparam int unsigned IDX_W  = $clog2(VERTEX_COUNT);
  localparam bit          RED_ON = (VERTEX_COUNT < (2 ** ufcf_pkg::VTX_W)) &&
                                   ((VERTEX_COUNT & (VERTEX_COUNT - 1)) != 0);
  // Reciprocal scaled by 2^RCP_SH and rounded up; the floor quotient is exact
  // for every 12-bit index while the depth stays below 2^12.
  localparam int unsigned RCP_SH = 2 * ufcf_pkg::VTX_W;
  localparam int unsigned PROD_W = RCP_SH + ufcf_pkg::VTX_W;
  localparam int unsigned BACK_W = 2 * ufcf_pkg::VTX_W;
  localparam logic [RCP_SH-1:0] RCP =
    RED_ON ? RCP_SH'(((2 ** RCP_SH) + VERTEX_COUNT - 1) / VERTEX_COUNT) : '0;

  logic                           busy;
  logic [ufcf_pkg::VTX_W-1:0]     rem;
  logic [ufcf_pkg::VTX_W-1:0]     quo;
  logic [PROD_W-1:0]              prod;
  logic [BACK_W-1:0]              back;
  logic [ufcf_pkg::VTX_W-1:0]     residue;
  logic [31:0]                    rem_ext;

  assign prod    = PROD_W'(rem) * PROD_W'(RCP);
  assign back    = BACK_W'(quo) * BACK_W'(VERTEX_COUNT);
  assign residue = rem - back[ufcf_pkg::VTX_W-1:0];
  assign rem_ext = RED_ON ? 32'(residue) : 32'(rem);
  assign idx     = rem_ext[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= raw;
    end
    if (busy) begin
      quo <= prod[RCP_SH +: ufcf_pkg::VTX_W];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/union_find_cycle_filter.sv
`default_nettype none

// Spanning-forest filter: union-find over a stream of edges.
// edges (sink): one request carries tail_vertex, tip_vertex and new_set.
//   new_set drops all sets before the edge is processed.
// result (source): one request per edge, added = 1 when the edge joins two
//   sets, added = 0 when it closes a cycle. Results leave in edge order.
// The block takes one edge at a time: edges.ready is high only while idle.
// Result valid comes once the parent steps to both roots are walked and path
// compression has rewritten its nodes; every step is one access of the
// single-port parent memory. The index wrap unit reduces the tail, then the
// tip, and takes as long at a power-of-two depth as at any other. The next
// edge is accepted once the result has moved into the output register.
// Each parent entry carries a generation tag; new_set advances the live
// generation, so stale entries read as unseen without touching memory.
// After reset, and on every 255th new_set, a clearing pass writes tag zero
// into all VERTEX_COUNT entries, one per cycle, while edges.ready stays low.
// A stalled receiver holds the result in the output register; the next edge
// is still accepted and worked, and its result waits until the register frees.
module union_find_cycle_filter #(
  parameter int unsigned VERTEX_COUNT = ufcf_pkg::VERTEX_COUNT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  ufcf_edge_if.sink     edges,
  ufcf_result_if.source result
);

  localparam int unsigned IDX_W = $clog2(VERTEX_COUNT);
  localparam int unsigned ENT_W = ufcf_pkg::TAG_W + IDX_W;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_WRAP_A = 9'b000000100,
    S_WRAP_B = 9'b000001000,
    S_ISSUE  = 9'b000010000,
    S_SEEN   = 9'b000100000,
    S_WALK   = 9'b001000000,
    S_PACK   = 9'b010000000,
    S_FOUND  = 9'b100000000
  } state_t;

  state_t state;

  // Parent memory: {generation tag, parent index} per vertex.
  logic [ENT_W-1:0] mem [VERTEX_COUNT];
  logic [ENT_W-1:0] rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic [ENT_W-1:0] mem_wdata;

  logic [ufcf_pkg::TAG_W-1:0] rd_tag;
  logic [IDX_W-1:0]           rd_par;

  logic [ufcf_pkg::TAG_W-1:0] epoch;
  logic [IDX_W-1:0]           clr_addr;
  logic                       clr_resume;
  logic [ufcf_pkg::VTX_W-1:0] tip_raw;
  logic                       new_set_r;
  logic [IDX_W-1:0]           va;
  logic [IDX_W-1:0]           vb;
  logic [IDX_W-1:0]           cur;
  logic [IDX_W-1:0]           root;
  logic [IDX_W-1:0]           ra;
  logic                       phase;
  logic                       pending;
  logic                       added_r;
  logic                       out_valid;
  logic                       out_added;

  logic [IDX_W-1:0]           v_cur;
  logic                       accept;

  logic                       wrap_start;
  logic [ufcf_pkg::VTX_W-1:0] wrap_raw;
  logic                       wrap_done;
  logic [IDX_W-1:0]           wrap_idx;

  assign rd_tag = rdata[ENT_W-1 -: ufcf_pkg::TAG_W];
  assign rd_par = rdata[IDX_W-1:0];
  assign v_cur  = phase ? vb : va;

  // Accept while idle and no finished result is still parked for the register.
  assign edges.ready   = (state == S_IDLE) && !pending;
  assign accept        = edges.valid && edges.ready;
  assign result.valid  = out_valid;
  assign result.added  = out_added;

  // The wrap unit serves the tail first, then the tip.
  assign wrap_start = accept || ((state == S_WRAP_A) && wrap_done);
  assign wrap_raw   = (state == S_IDLE) ? edges.tail_vertex : tip_raw;

  ufcf_wrap #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_wrap (
    .clk   (clk),
    .rst   (rst),
    .start (wrap_start),
    .raw   (wrap_raw),
    .done  (wrap_done),
    .idx   (wrap_idx)
  );

  // Single port, read-first: compression reads the old parent and writes the
  // root at the same address in a single access.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // Memory port steering per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = {ufcf_pkg::TAG_NONE, IDX_W'(0)};
      end
      S_ISSUE: begin
        mem_addr = v_cur;
      end
      S_SEEN: begin
        if (rd_tag != epoch) begin
          // First sight in this generation: make the vertex its own root.
          mem_we    = 1'b1;
          mem_addr  = v_cur;
          mem_wdata = {epoch, v_cur};
        end else begin
          mem_addr = rd_par;
        end
      end
      S_WALK: begin
        if (rd_par == cur) begin
          // Root found: start compression at the endpoint itself.
          mem_we    = 1'b1;
          mem_addr  = v_cur;
          mem_wdata = {epoch, cur};
        end else begin
          mem_addr = rd_par;
        end
      end
      S_PACK: begin
        if (rd_par != root) begin
          mem_we    = 1'b1;
          mem_addr  = rd_par;
          mem_wdata = {epoch, root};
        end
      end
      S_FOUND: begin
        if (phase && (ra != root)) begin
          // Link the tail's root under the tip's root.
          mem_we    = 1'b1;
          mem_addr  = ra;
          mem_wdata = {epoch, root};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_resume <= 1'b0;
      epoch      <= ufcf_pkg::TAG_FIRST;
      phase      <= 1'b0;
      pending    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Refill the output register from a parked result, or drain it.
      if (pending && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
        out_added <= added_r;
        pending   <= 1'b0;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(VERTEX_COUNT - 1)) begin
            clr_addr <= '0;
            epoch    <= ufcf_pkg::TAG_FIRST;
            state    <= clr_resume ? S_ISSUE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            tip_raw   <= edges.tip_vertex;
            new_set_r <= edges.new_set;
            state     <= S_WRAP_A;
          end
        end
        S_WRAP_A: begin
          if (wrap_done) begin
            va    <= wrap_idx;
            state <= S_WRAP_B;
          end
        end
        S_WRAP_B: begin
          if (wrap_done) begin
            vb    <= wrap_idx;
            phase <= 1'b0;
            if (new_set_r && (epoch == ufcf_pkg::TAG_LAST)) begin
              // Tags would wrap: sweep the memory, then resume this edge.
              clr_resume <= 1'b1;
              state      <= S_CLEAR;
            end else begin
              if (new_set_r) begin
                epoch <= epoch + 1'b1;
              end
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          state <= S_SEEN;
        end
        S_SEEN: begin
          if (rd_tag != epoch) begin
            root  <= v_cur;
            state <= S_FOUND;
          end else if (rd_par == v_cur) begin
            root  <= v_cur;
            state <= S_FOUND;
          end else begin
            cur   <= rd_par;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_par == cur) begin
            root  <= cur;
            state <= S_PACK;
          end else begin
            cur <= rd_par;
          end
        end
        S_PACK: begin
          if (rd_par == root) begin
            state <= S_FOUND;
          end
        end
        S_FOUND: begin
          if (!phase) begin
            ra    <= root;
            phase <= 1'b1;
            state <= S_ISSUE;
          end else begin
            added_r    <= (ra != root);
            pending    <= 1'b1;
            clr_resume <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
